// ----- sv/rbflms_pkg.sv -----
// shared types and constants for the radial basis lms learner
package rbflms_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_LEARNING_RATE  = 3'd0;
  localparam logic [2:0] CFG_WIDTH_SCALE    = 3'd1;
  localparam logic [2:0] CFG_GRID_SPACING   = 3'd2;
  localparam logic [2:0] CFG_FIRST_CENTER_X = 3'd3;
  localparam logic [2:0] CFG_FIRST_CENTER_Y = 3'd4;

  // item operation codes
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // reset values of the registers
  localparam logic [15:0] RST_LEARNING_RATE  = 16'd3277;
  localparam logic [15:0] RST_WIDTH_SCALE    = 16'd41722;
  localparam logic [14:0] RST_GRID_SPACING   = 15'd3217;
  localparam logic [15:0] RST_FIRST_CENTER_X = 16'hF36F;
  localparam logic [15:0] RST_FIRST_CENTER_Y = 16'h0000;

  // exp(-1/16) in Q0.32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748381;

  typedef struct packed {
    logic load_item;
    logic clear_wr;
    logic comp_issue;
    logic last_col;
    logic upd_issue;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } status_t;

  // saturate a 33-bit signed value to 32 bits
  function automatic logic [31:0] sat33(logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/gaussian_rbf_lms_learner.sv -----
// top level of the gaussian radial basis network with lms learning
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, op, angles,  | item in
//          | errors                           |
//  out     | out_valid, out_stall, corrections| item out
//  cfg     | cfg_write, cfg_index, cfg_data   | write only
//
// compute item: each cycle issues one cell into the distance, exp and weighted
// sum pipeline; the result is loaded once the pipeline has drained and the output
// register is free, and the controller is then idle for the next item
// update item: every cell is issued, and the next item waits until the pipeline drains
// after reset a clearing pass over every cell zeroes both stores
// a waiting result does not block the next item; only the next result waits
module gaussian_rbf_lms_learner #(
  parameter int GRID_COLUMNS    = 6,
  parameter int GRID_ROWS       = 4,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [15:0] angle_first,
  input  logic signed [15:0] angle_second,
  input  logic signed [15:0] error_first,
  input  logic signed [15:0] error_second,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] correction_first,
  output logic signed [31:0] correction_second
);

  localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
  localparam int CIW        = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  rbflms_pkg::cmd_t    cmd;
  rbflms_pkg::status_t status;
  logic [CIW-1:0]      cell_idx;

  rbflms_ctrl #(
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_op   (op),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd),
    .cell_idx(cell_idx)
  );

  rbflms_dp #(
    .GRID_COLUMNS   (GRID_COLUMNS),
    .GRID_ROWS      (GRID_ROWS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .angle_first      (angle_first),
    .angle_second     (angle_second),
    .error_first      (error_first),
    .error_second     (error_second),
    .cmd              (cmd),
    .cell_idx         (cell_idx),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .correction_first (correction_first),
    .correction_second(correction_second)
  );

endmodule

// ----- sv/rbflms_ctrl.sv -----
// sequencer for clearing, compute and update passes over the grid cells
module rbflms_ctrl #(
  parameter int GRID_COLUMNS = 6,
  parameter int GRID_ROWS    = 4,
  localparam int CELL_COUNT  = GRID_COLUMNS * GRID_ROWS,
  localparam int CIW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1,
  localparam int COLW        = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  input  rbflms_pkg::status_t status,
  output rbflms_pkg::cmd_t  cmd,
  output logic [CIW-1:0]    cell_idx
);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_CLEAR      = 7'b0000010,
    S_COMP       = 7'b0000100,
    S_COMP_DRAIN = 7'b0001000,
    S_DELIVER    = 7'b0010000,
    S_UPD        = 7'b0100000,
    S_UPD_DRAIN  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [CIW-1:0]  cell_idx_next;
  logic [COLW-1:0] col, col_next;
  logic last_cell, last_col;

  assign last_cell = (cell_idx == CIW'(CELL_COUNT - 1));
  assign last_col  = (col == COLW'(GRID_COLUMNS - 1));
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cell_idx_next = cell_idx;
    col_next      = col;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        cell_idx_next = '0;
        col_next      = '0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = (in_op == rbflms_pkg::OP_COMPUTE) ? S_COMP : S_UPD;
        end
      end
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cell_idx_next = cell_idx + 1'b1;
        if (last_cell) begin
          state_next = S_IDLE;
        end
      end
      S_COMP: begin
        cmd.comp_issue = 1'b1;
        cmd.last_col   = last_col;
        cell_idx_next = cell_idx + 1'b1;
        col_next  = last_col ? '0 : col + 1'b1;
        if (last_cell) begin
          state_next = S_COMP_DRAIN;
        end
      end
      S_COMP_DRAIN: begin
        if (!status.busy) begin
          state_next = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (!status.out_full) begin
          cmd.result_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UPD: begin
        cmd.upd_issue = 1'b1;
        cell_idx_next = cell_idx + 1'b1;
        if (last_cell) begin
          state_next = S_UPD_DRAIN;
        end
      end
      S_UPD_DRAIN: begin
        if (!status.busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cell_idx <= '0;
      col      <= '0;
    end else begin
      state    <= state_next;
      cell_idx <= cell_idx_next;
      col      <= col_next;
    end
  end

  a_result_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!status.busy && !status.out_full))
    else $error("result loaded while pipeline busy or output full");

  a_item_into_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |-> !status.busy)
    else $error("item taken while pipeline still busy");

  a_comp_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP && last_cell) |=> (state == S_COMP_DRAIN))
    else $error("compute pass did not end after last cell");

  a_no_mixed_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> (!status.busy && !cmd.comp_issue && !cmd.upd_issue))
    else $error("clearing pass overlaps other work");

endmodule

// ----- sv/rbflms_dp.sv -----
// datapath: centre stepping, distance and exp pipeline, weight and activation stores
module rbflms_dp #(
  parameter int GRID_COLUMNS    = 6,
  parameter int GRID_ROWS       = 4,
  parameter int EXP_TABLE_DEPTH = 256,
  localparam int CELL_COUNT     = GRID_COLUMNS * GRID_ROWS,
  localparam int CIW            = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] angle_first,
  input  logic signed [15:0] angle_second,
  input  logic signed [15:0] error_first,
  input  logic signed [15:0] error_second,
  input  rbflms_pkg::cmd_t   cmd,
  input  logic [CIW-1:0]     cell_idx,
  output rbflms_pkg::status_t status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] correction_first,
  output logic signed [31:0] correction_second
);

  localparam int GMAX  = (GRID_COLUMNS > GRID_ROWS) ? GRID_COLUMNS : GRID_ROWS;
  localparam int CTR_W = 17 + $clog2(GMAX);
  localparam int DW    = CTR_W + 1;
  localparam int SQW   = 2 * DW;
  localparam int SUMW  = SQW + 1;
  localparam int XW    = SUMW + 16;
  localparam int HW    = XW - 36;
  localparam int IW    = $clog2(EXP_TABLE_DEPTH);
  localparam int AW    = 49 + CIW;

  function automatic logic [EXP_TABLE_DEPTH*16-1:0] build_exp();
    logic [EXP_TABLE_DEPTH*16-1:0] rom;
    logic [63:0] e;
    logic [63:0] q;
    rom = '0;
    e   = 64'h1_0000_0000;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      q = (e + 64'h8000) >> 16;
      rom[k*16 +: 16] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      e = (e * rbflms_pkg::EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
    return rom;
  endfunction

  localparam logic [EXP_TABLE_DEPTH*16-1:0] EXP_ROM = build_exp();

  // configuration
  logic [15:0] learning_rate, width_scale;
  logic [14:0] grid_spacing;
  logic [15:0] first_center_x, first_center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate  <= rbflms_pkg::RST_LEARNING_RATE;
      width_scale    <= rbflms_pkg::RST_WIDTH_SCALE;
      grid_spacing   <= rbflms_pkg::RST_GRID_SPACING;
      first_center_x <= rbflms_pkg::RST_FIRST_CENTER_X;
      first_center_y <= rbflms_pkg::RST_FIRST_CENTER_Y;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rbflms_pkg::CFG_LEARNING_RATE:  learning_rate  <= cfg_data;
        rbflms_pkg::CFG_WIDTH_SCALE:    width_scale    <= cfg_data;
        rbflms_pkg::CFG_GRID_SPACING:   grid_spacing   <= cfg_data[14:0];
        rbflms_pkg::CFG_FIRST_CENTER_X: first_center_x <= cfg_data;
        rbflms_pkg::CFG_FIRST_CENTER_Y: first_center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture and centre stepping
  logic signed [15:0] a0, a1, e0, e1;
  logic signed [CTR_W-1:0] cx, cy, fcx, fcy, sp;

  assign fcx = {{(CTR_W-16){first_center_x[15]}}, first_center_x};
  assign fcy = {{(CTR_W-16){first_center_y[15]}}, first_center_y};
  assign sp  = {{(CTR_W-15){1'b0}}, grid_spacing};

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      a0 <= angle_first;
      a1 <= angle_second;
      e0 <= error_first;
      e1 <= error_second;
      cx <= fcx;
      cy <= fcy;
    end else if (cmd.comp_issue) begin
      if (cmd.last_col) begin
        cx <= fcx;
        cy <= cy + sp;
      end else begin
        cx <= cx + sp;
      end
    end
  end

  // compute pipeline
  logic v1, v2, v3, v4, v5, v6;
  logic [CIW-1:0] ad1, ad2, ad3, ad4, ad5;
  logic signed [DW-1:0] dx1, dy1;
  logic signed [SQW-1:0] sqx_s, sqy_s;
  logic [SQW-1:0] sqx2, sqy2;
  logic [SUMW-1:0] sum3;
  logic [XW-1:0] x_w;
  logic oor4;
  logic [IW-1:0] idx4;
  logic [15:0] p5;
  logic signed [48:0] pr0_w, pr1_w, pr0_6, pr1_6;
  logic signed [AW-1:0] acc0, acc1;

  assign sqx_s = dx1 * dx1;
  assign sqy_s = dy1 * dy1;
  assign x_w   = XW'(sum3) * XW'(width_scale);

  // weight and activation stores
  logic [63:0] wmem [CELL_COUNT];
  logic [15:0] amem [CELL_COUNT];
  logic [63:0] wrd;
  logic [15:0] ard;
  logic [CIW-1:0] w_raddr;

  assign w_raddr = cmd.upd_issue ? cell_idx : ad4;
  assign pr0_w = $signed(wrd[31:0]) * $signed({1'b0, p5});
  assign pr1_w = $signed(wrd[63:32]) * $signed({1'b0, p5});

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
      acc0 <= '0;
      acc1 <= '0;
    end else begin
      v1 <= cmd.comp_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      if (cmd.load_item) begin
        acc0 <= '0;
        acc1 <= '0;
      end else if (v6) begin
        acc0 <= acc0 + AW'(pr0_6);
        acc1 <= acc1 + AW'(pr1_6);
      end
    end
  end

  always_ff @(posedge clk) begin
    ad1  <= cell_idx;
    ad2  <= ad1;
    ad3  <= ad2;
    ad4  <= ad3;
    ad5  <= ad4;
    dx1  <= DW'(a0) - DW'(cx);
    dy1  <= DW'(a1) - DW'(cy);
    sqx2 <= sqx_s;
    sqy2 <= sqy_s;
    sum3 <= SUMW'(sqx2) + SUMW'(sqy2);
    oor4 <= (x_w[XW-1:36] >= HW'(EXP_TABLE_DEPTH));
    idx4 <= x_w[36 +: IW];
    // beyond the table the activation is zero
    p5   <= oor4 ? 16'd0 : EXP_ROM[idx4*16 +: 16];
    pr0_6 <= pr0_w;
    pr1_6 <= pr1_w;
  end

  // update pipeline
  logic uv1, uv2, uv3, uv4;
  logic [CIW-1:0] ua1, ua2, ua3, ua4;
  logic [31:0] rp2;
  logic [63:0] uw2, uw3, uw4;
  logic signed [48:0] up0_3, up1_3;
  logic signed [49:0] rnd0, rnd1;
  logic signed [21:0] d0_4, d1_4;
  logic [31:0] nw0, nw1;

  assign rnd0 = 50'(up0_3) + 50'sd134217728;
  assign rnd1 = 50'(up1_3) + 50'sd134217728;
  assign nw0 = rbflms_pkg::sat33($signed({uw4[31], uw4[31:0]})
                                 - $signed({{11{d0_4[21]}}, d0_4}));
  assign nw1 = rbflms_pkg::sat33($signed({uw4[63], uw4[63:32]})
                                 - $signed({{11{d1_4[21]}}, d1_4}));

  always_ff @(posedge clk) begin
    if (rst) begin
      {uv1, uv2, uv3, uv4} <= '0;
    end else begin
      uv1 <= cmd.upd_issue;
      uv2 <= uv1;
      uv3 <= uv2;
      uv4 <= uv3;
    end
  end

  always_ff @(posedge clk) begin
    ua1   <= cell_idx;
    ua2   <= ua1;
    ua3   <= ua2;
    ua4   <= ua3;
    rp2   <= 32'(learning_rate) * 32'(ard);
    uw2   <= wrd;
    uw3   <= uw2;
    uw4   <= uw3;
    up0_3 <= $signed({1'b0, rp2}) * e0;
    up1_3 <= $signed({1'b0, rp2}) * e1;
    d0_4  <= rnd0[49:28];
    d1_4  <= rnd1[49:28];
  end

  always_ff @(posedge clk) begin
    wrd <= wmem[w_raddr];
    ard <= amem[cell_idx];
    if (cmd.clear_wr) begin
      wmem[cell_idx] <= '0;
    end else if (uv4) begin
      wmem[ua4] <= {nw1, nw0};
    end
    if (cmd.clear_wr) begin
      amem[cell_idx] <= '0;
    end else if (v5) begin
      amem[ad5] <= p5;
    end
  end

  // result saturation and output register
  logic fit0, fit1;
  logic [31:0] res0, res1;

  assign fit0 = (acc0[AW-1:47] == {(AW-47){acc0[47]}});
  assign fit1 = (acc1[AW-1:47] == {(AW-47){acc1[47]}});
  assign res0 = fit0 ? acc0[47:16] : (acc0[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign res1 = fit1 ? acc1[47:16] : (acc1[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      correction_first  <= res0;
      correction_second <= res1;
    end
  end

  assign status.busy     = v1 | v2 | v3 | v4 | v5 | v6 | uv1 | uv2 | uv3 | uv4;
  assign status.out_full = out_valid;

endmodule

// ----- dv/gaussian_rbf_lms_learner_tb.sv -----
// self-checking testbench for the gaussian radial basis lms learner
module gaussian_rbf_lms_learner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 6;
  localparam int ROWS = 4;
  localparam int CELLS = COLS * ROWS;
  localparam int LUT_DEPTH = 256;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic signed [31:0] first;
    logic signed [31:0] second;
  } correction_t;

  typedef struct {
    logic op;
    logic signed [15:0] a_first;
    logic signed [15:0] a_second;
    logic signed [15:0] e_first;
    logic signed [15:0] e_second;
    bit known;
    logic signed [31:0] x_first;
    logic signed [31:0] x_second;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = rbflms_pkg::OP_COMPUTE;
  logic signed [15:0] angle_first = '0;
  logic signed [15:0] angle_second = '0;
  logic signed [15:0] error_first = '0;
  logic signed [15:0] error_second = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] correction_first;
  logic signed [31:0] correction_second;

  gaussian_rbf_lms_learner dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .angle_first(angle_first), .angle_second(angle_second),
    .error_first(error_first), .error_second(error_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .correction_first(correction_first), .correction_second(correction_second)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [15:0] exp_lut [LUT_DEPTH];
  logic [15:0] rate_q16;
  logic [15:0] scale_q16;
  logic [14:0] pitch;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic signed [31:0] w_first [CELLS];
  logic signed [31:0] w_second [CELLS];
  logic [15:0] activation [CELLS];

  correction_t pending_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int computes_sent = 0;
  int updates_sent = 0;
  bit quiet = 1'b0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic reset_predictor();
    longint unsigned e;
    longint unsigned q;
    e = 64'd1 << 32;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      q = (e + 64'h8000) >> 16;
      exp_lut[k] = (q > 65535) ? 16'hFFFF : q[15:0];
      e = (e * 64'd4034748381 + (64'd1 << 31)) >> 32;
    end
    rate_q16 = rbflms_pkg::RST_LEARNING_RATE;
    scale_q16 = rbflms_pkg::RST_WIDTH_SCALE;
    pitch = rbflms_pkg::RST_GRID_SPACING;
    origin_x = rbflms_pkg::RST_FIRST_CENTER_X;
    origin_y = rbflms_pkg::RST_FIRST_CENTER_Y;
    for (int i = 0; i < CELLS; i++) begin
      w_first[i] = '0;
      w_second[i] = '0;
      activation[i] = '0;
    end
  endtask

  function automatic correction_t predict_correction(logic signed [15:0] a0,
                                                     logic signed [15:0] a1);
    correction_t res;
    longint d0, d1, sq, x, s0, s1;
    s0 = 0;
    s1 = 0;
    for (int r = 0; r < ROWS; r++) begin
      d1 = longint'(a1) - (longint'(origin_y) + r * longint'(pitch));
      for (int c = 0; c < COLS; c++) begin
        d0 = longint'(a0) - (longint'(origin_x) + c * longint'(pitch));
        sq = d0 * d0 + d1 * d1;
        x = (sq * longint'(scale_q16)) >>> 36;
        activation[r * COLS + c] = (x < LUT_DEPTH) ? exp_lut[x] : 16'd0;
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      s0 += longint'(w_first[i]) * longint'(activation[i]);
      s1 += longint'(w_second[i]) * longint'(activation[i]);
    end
    res.first = sat32(s0 >>> 16);
    res.second = sat32(s1 >>> 16);
    return res;
  endfunction

  task automatic apply_lms_update(logic signed [15:0] e0, logic signed [15:0] e1);
    longint rp, d0, d1;
    for (int i = 0; i < CELLS; i++) begin
      rp = longint'(rate_q16) * longint'(activation[i]);
      d0 = (rp * longint'(e0) + (64'sd1 <<< 27)) >>> 28;
      d1 = (rp * longint'(e1) + (64'sd1 <<< 27)) >>> 28;
      w_first[i] = sat32(longint'(w_first[i]) - d0);
      w_second[i] = sat32(longint'(w_second[i]) - d1);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      rbflms_pkg::CFG_LEARNING_RATE: rate_q16 = val;
      rbflms_pkg::CFG_WIDTH_SCALE: scale_q16 = val;
      rbflms_pkg::CFG_GRID_SPACING: pitch = val[14:0];
      rbflms_pkg::CFG_FIRST_CENTER_X: origin_x = val;
      rbflms_pkg::CFG_FIRST_CENTER_Y: origin_y = val;
      default: ;
    endcase
  endtask

  // updates leave no result behind, so give the pipeline time to empty
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(dir_row_t row);
    correction_t res;
    int gap;
    gap = quiet ? 0 : int'($urandom_range(0, 9));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= row.op;
    angle_first <= row.a_first;
    angle_second <= row.a_second;
    error_first <= row.e_first;
    error_second <= row.e_second;
    do @(posedge clk); while (in_stall);
    if (row.op == rbflms_pkg::OP_COMPUTE) begin
      res = predict_correction(row.a_first, row.a_second);
      if (row.known) begin
        res.first = row.x_first;
        res.second = row.x_second;
      end
      pending_q = {pending_q, res};
      computes_sent++;
    end else begin
      apply_lms_update(row.e_first, row.e_second);
      updates_sent++;
    end
  endtask

  function automatic logic signed [15:0] near_centre(logic signed [15:0] base, int k);
    return 16'(int'(base) + k * int'(pitch) + int'($urandom_range(0, 4000)) - 2000);
  endfunction

  task automatic random_phase(int count);
    dir_row_t row;
    int n;
    n = 0;
    while (n < count) begin
      row.known = 1'b0;
      if ($urandom_range(0, 4) != 0) begin
        // well-formed: a compute near a centre followed by its error update
        row.op = rbflms_pkg::OP_COMPUTE;
        row.a_first = near_centre(origin_x, int'($urandom_range(0, COLS - 1)));
        row.a_second = near_centre(origin_y, int'($urandom_range(0, ROWS - 1)));
        row.e_first = 16'($urandom);
        row.e_second = 16'($urandom);
        send_item(row);
        row.op = rbflms_pkg::OP_UPDATE;
        if ($urandom_range(0, 1) != 0) begin
          row.e_first = $signed(16'($urandom)) >>> $urandom_range(0, 12);
          row.e_second = $signed(16'($urandom)) >>> $urandom_range(0, 12);
        end
        send_item(row);
        n += 2;
      end else begin
        row.op = 1'($urandom_range(0, 1));
        row.a_first = 16'($urandom);
        row.a_second = 16'($urandom);
        row.e_first = 16'($urandom);
        row.e_second = 16'($urandom);
        send_item(row);
        n++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // result side: stall draw per item, checked against the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    int nxt;
    correction_t want;
    nxt = stall_left;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d %0d", correction_first, correction_second);
      end else begin
        want = pending_q.pop_front();
        if (want.first !== correction_first || want.second !== correction_second) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d, got %0d %0d", want.first,
                     want.second, correction_first, correction_second);
        end
      end
      nxt = quiet ? 0 : int'($urandom_range(0, 9));
    end else if (nxt != 0) begin
      nxt = nxt - 1;
    end
    stall_left <= nxt;
    out_stall <= (nxt != 0);
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t dir_tab [12];
    dir_tab = '{
      // update before any compute leaves the weights at zero
      '{rbflms_pkg::OP_UPDATE, 16'sh0000, 16'sh0000, 16'sh7FFF, -16'sh8000, 1'b0, 0, 0},
      '{rbflms_pkg::OP_COMPUTE, -16'sh8000, -16'sh8000, 16'sh0, 16'sh0, 1'b1, 0, 0},
      '{rbflms_pkg::OP_COMPUTE, 16'sh7FFF, 16'sh7FFF, 16'sh0, 16'sh0, 1'b1, 0, 0},
      '{rbflms_pkg::OP_COMPUTE, -16'sd3217, 16'sh0, 16'sh0, 16'sh0, 1'b0, 0, 0},
      '{rbflms_pkg::OP_UPDATE, 16'sh0, 16'sh0, 16'sh7FFF, -16'sh8000, 1'b0, 0, 0},
      '{rbflms_pkg::OP_COMPUTE, -16'sd3217, 16'sh0, 16'sh0, 16'sh0, 1'b0, 0, 0},
      '{rbflms_pkg::OP_UPDATE, 16'sh0, 16'sh0, -16'sh8000, 16'sh7FFF, 1'b0, 0, 0},
      '{rbflms_pkg::OP_COMPUTE, 16'sh0, 16'sd3217, 16'sh0, 16'sh0, 1'b0, 0, 0},
      '{rbflms_pkg::OP_UPDATE, 16'sh0, 16'sh0, 16'sh1, -16'sh1, 1'b0, 0, 0},
      '{rbflms_pkg::OP_COMPUTE, 16'sh7FFF, -16'sh8000, 16'sh0, 16'sh0, 1'b0, 0, 0},
      '{rbflms_pkg::OP_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 0, 0},
      '{rbflms_pkg::OP_COMPUTE, -16'sd3217, 16'sh0, 16'sh0, 16'sh0, 1'b0, 0, 0}
    };
    reset_predictor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    quiet = 1'b1;
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    in_valid <= 1'b0;
    quiet = 1'b0;
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    in_valid <= 1'b0;

    // extremes: rate, pitch at both ends, flat activations, corner origins
    drain();
    write_reg(rbflms_pkg::CFG_LEARNING_RATE, 16'hFFFF);
    write_reg(rbflms_pkg::CFG_WIDTH_SCALE, 16'h0000);
    write_reg(3'd5, 16'h1234);
    write_reg(3'd7, 16'hFFFF);
    random_phase(150);
    drain();
    write_reg(rbflms_pkg::CFG_WIDTH_SCALE, 16'hFFFF);
    write_reg(rbflms_pkg::CFG_GRID_SPACING, 16'hFFFF);
    write_reg(rbflms_pkg::CFG_FIRST_CENTER_X, 16'h8000);
    write_reg(rbflms_pkg::CFG_FIRST_CENTER_Y, 16'h7FFF);
    random_phase(150);
    drain();
    write_reg(rbflms_pkg::CFG_LEARNING_RATE, 16'h0000);
    write_reg(rbflms_pkg::CFG_GRID_SPACING, 16'h8000);
    write_reg(rbflms_pkg::CFG_FIRST_CENTER_X, 16'h7FFF);
    write_reg(rbflms_pkg::CFG_FIRST_CENTER_Y, 16'h8000);
    random_phase(100);
    drain();
    write_reg(rbflms_pkg::CFG_LEARNING_RATE, rbflms_pkg::RST_LEARNING_RATE);
    write_reg(rbflms_pkg::CFG_WIDTH_SCALE, rbflms_pkg::RST_WIDTH_SCALE);
    write_reg(rbflms_pkg::CFG_GRID_SPACING, {1'b0, rbflms_pkg::RST_GRID_SPACING});
    write_reg(rbflms_pkg::CFG_FIRST_CENTER_X, rbflms_pkg::RST_FIRST_CENTER_X);
    write_reg(rbflms_pkg::CFG_FIRST_CENTER_Y, rbflms_pkg::RST_FIRST_CENTER_Y);
    quiet = 1'b1;
    random_phase(150);
    quiet = 1'b0;
    random_phase(100);
    for (int p = 0; p < 3; p++) begin
      drain();
      write_reg(rbflms_pkg::CFG_LEARNING_RATE, 16'($urandom));
      write_reg(rbflms_pkg::CFG_WIDTH_SCALE,
                16'($urandom_range(0, 65535) >> $urandom_range(0, 8)));
      write_reg(rbflms_pkg::CFG_GRID_SPACING, 16'($urandom_range(0, 6000)));
      write_reg(rbflms_pkg::CFG_FIRST_CENTER_X,
                16'(int'($urandom_range(0, 20000)) - 16000));
      write_reg(rbflms_pkg::CFG_FIRST_CENTER_Y,
                16'(int'($urandom_range(0, 20000)) - 10000));
      random_phase(130);
    end

    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d compute and %0d update items, checked %0d results",
             computes_sent, updates_sent, results_seen);
    $display("covered default, extreme and random register settings; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
